FILE: hdl/itor_pkg.sv
// ----------------------------------------------------------------------------
// itor_pkg
// Shared constants, kind codes and the digit-to-character function of the
// integer to ASCII converter.
// ----------------------------------------------------------------------------
package itor_pkg;

    localparam int NUM_W      = 32;
    localparam int USER_W     = 4;
    localparam int CHAR_W     = 8;
    localparam int DIG_W      = 4;
    localparam int NDIG       = 11;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * DIG_W;
    localparam int DIGS_W     = NDIG * DIG_W;

    localparam logic [2:0] KIND_SDEC = 3'd0;
    localparam logic [2:0] KIND_UDEC = 3'd1;
    localparam logic [2:0] KIND_OCT  = 3'd2;
    localparam logic [2:0] KIND_UHEX = 3'd3;
    localparam logic [2:0] KIND_LHEX = 3'd4;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    function automatic logic [CHAR_W-1:0] itor_ascii(input logic [DIG_W-1:0] d,
                                                     input logic lower);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIG_W){1'b0}}, d};
        if (d < 4'd10)
        begin
            itor_ascii = CH_ZERO + dx;
        end
        else
        begin
            itor_ascii = (lower ? CH_LA : CH_UA) + dx - 8'd10;
        end
    endfunction

endpackage

FILE: hdl/itor_bcd_step.sv
// ----------------------------------------------------------------------------
// itor_bcd_step
// One shift-and-add-3 step of binary to BCD conversion over all digits.
// ----------------------------------------------------------------------------
module itor_bcd_step
(
    input  logic [itor_pkg::BCD_W-1:0] bcd_in,
    input  logic                       bit_in,
    output logic [itor_pkg::BCD_W-1:0] bcd_out
);
    import itor_pkg::*;

    logic [BCD_W-1:0] adj;

    always_comb
    begin
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (bcd_in[k*DIG_W +: DIG_W] >= 4'd5)
            begin
                adj[k*DIG_W +: DIG_W] = bcd_in[k*DIG_W +: DIG_W] + 4'd3;
            end
            else
            begin
                adj[k*DIG_W +: DIG_W] = bcd_in[k*DIG_W +: DIG_W];
            end
        end
        bcd_out = {adj[BCD_W-2:0], bit_in};
    end

endmodule

FILE: hdl/integer_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts one integer to ASCII sign and digit characters, most significant
// first, in signed/unsigned decimal, octal or upper/lower-case hex.
// ----------------------------------------------------------------------------
// One number is taken per conversion and the input stays not ready until its
// last character has been handed to the output register. A number is first
// loaded; for decimal kinds its argument bits (32 when wide, INT_WIDTH
// otherwise) then pass one bit per cycle through the shared shift-and-add-3
// BCD unit. Suppressed leading zero digits are then skipped, and each
// character (sign included) leaves through the single digit shift register,
// one per cycle unless the output stalls. Octal and hex skip the BCD pass.
// A beat with no meaningful kind converts as unsigned decimal.
module integer_to_ascii_radix
#(
    parameter int INT_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [itor_pkg::NUM_W-1:0]    s_axis_tdata,   // number[31:0]
    input  logic [itor_pkg::USER_W-1:0]   s_axis_tuser,   // wide[0], kind[3:1]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [itor_pkg::CHAR_W-1:0]   m_axis_tdata,   // character[7:0]
    output logic                          m_axis_tlast
);
    import itor_pkg::*;

    localparam logic [NUM_W:0]   MASK33   = (33'd1 << INT_WIDTH) - 33'd1;
    localparam int               SHL      = NUM_W - INT_WIDTH;
    localparam logic [5:0]       W_NARROW = 6'(INT_WIDTH);
    localparam logic [5:0]       W_WIDE   = 6'(NUM_W);

    typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SKIP, ST_EMIT} state_t;

    state_t              state_reg, state_next;
    logic [DIGS_W-1:0]   dig_reg, dig_next;
    logic [NUM_W-1:0]    sh_reg, sh_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [3:0]          ndig_reg, ndig_next;
    logic                lower_reg, lower_next;
    logic                sign_reg, sign_next;
    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;

    logic                wide_in;
    logic [2:0]          kind_in;
    logic [NUM_W-1:0]    wmask, val, mag, aligned;
    logic                msb, neg;
    logic [NUM_W:0]      oct33;
    logic [DIGS_W-1:0]   oct_dig;
    logic [BCD_W-1:0]    bcd_out;
    logic                out_free;

    assign wide_in = s_axis_tuser[0];
    assign kind_in = s_axis_tuser[3:1];
    assign wmask   = wide_in ? {NUM_W{1'b1}} : MASK33[NUM_W-1:0];
    assign val     = s_axis_tdata & wmask;
    assign msb     = wide_in ? s_axis_tdata[NUM_W-1] : s_axis_tdata[INT_WIDTH-1];
    assign neg     = (kind_in == KIND_SDEC) && msb;
    assign mag     = neg ? ((32'd0 - val) & wmask) : val;
    assign aligned = wide_in ? mag : (mag << SHL);
    assign oct33   = {1'b0, val};

    always_comb
    begin
        for (int k = 0; k < NDIG; k++)
        begin
            oct_dig[k*DIG_W +: DIG_W] = {1'b0, oct33[k*3 +: 3]};
        end
    end

    itor_bcd_step u_bcd
    (
        .bcd_in  (dig_reg[DIGS_W-1:DIG_W]),
        .bit_in  (sh_reg[NUM_W-1]),
        .bcd_out (bcd_out)
    );

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    always_comb
    begin
        state_next   = state_reg;
        dig_next     = dig_reg;
        sh_next      = sh_reg;
        cnt_next     = cnt_reg;
        ndig_next    = ndig_reg;
        lower_next   = lower_reg;
        sign_next    = sign_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    lower_next = (kind_in == KIND_LHEX);
                    sign_next  = 1'b0;
                    case (kind_in)
                        KIND_OCT:
                        begin
                            dig_next   = oct_dig;
                            ndig_next  = 4'(NDIG);
                            state_next = ST_SKIP;
                        end
                        KIND_UHEX, KIND_LHEX:
                        begin
                            dig_next   = {val, {(DIGS_W-NUM_W){1'b0}}};
                            ndig_next  = 4'd8;
                            state_next = ST_SKIP;
                        end
                        default:
                        begin
                            dig_next   = '0;
                            sh_next    = aligned;
                            cnt_next   = wide_in ? W_WIDE : W_NARROW;
                            ndig_next  = 4'(BCD_DIGITS);
                            sign_next  = neg;
                            state_next = ST_CONV;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                dig_next = {bcd_out, {DIG_W{1'b0}}};
                sh_next  = {sh_reg[NUM_W-2:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (dig_reg[DIGS_W-1 -: DIG_W] == 4'd0 && ndig_reg > 4'd1)
                begin
                    dig_next  = {dig_reg[DIGS_W-DIG_W-1:0], {DIG_W{1'b0}}};
                    ndig_next = ndig_reg - 4'd1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        m_data_next = CH_MINUS;
                        m_last_next = 1'b0;
                        sign_next   = 1'b0;
                    end
                    else
                    begin
                        m_data_next = itor_ascii(dig_reg[DIGS_W-1 -: DIG_W], lower_reg);
                        m_last_next = (ndig_reg == 4'd1);
                        dig_next    = {dig_reg[DIGS_W-DIG_W-1:0], {DIG_W{1'b0}}};
                        ndig_next   = ndig_reg - 4'd1;
                        if (ndig_reg == 4'd1)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            sign_reg    <= 1'b0;
            cnt_reg     <= '0;
            ndig_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            sign_reg    <= sign_next;
            cnt_reg     <= cnt_next;
            ndig_reg    <= ndig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg    <= dig_next;
        sh_reg     <= sh_next;
        lower_reg  <= lower_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a beat was taken");

    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> ndig_reg != 4'd0)
        else $error("emitting with no digit left");

    a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONV |-> cnt_reg != 6'd0 && cnt_reg <= W_WIDE)
        else $error("BCD step count out of range");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_data_reg == CH_MINUS |-> !m_last_reg)
        else $error("sign marked as final character");

endmodule
